/* rtl/core/dxtba_pkg.sv */
// shared types and palette arithmetic for the dxt1 block with alpha decoder
package dxtba_pkg;

  localparam int unsigned PixelsPerBlock = 16;
  localparam int unsigned CountWidth = $clog2(PixelsPerBlock);
  // floor(x / 3) == (x * Recip3) >> Recip3Shift for every x below 2048
  localparam int unsigned Recip3 = 683;
  localparam int unsigned Recip3Shift = 11;

  typedef struct packed {
    logic [15:0] color_endpoint0;
    logic [15:0] color_endpoint1;
    logic [31:0] color_indices;
    logic [15:0] alpha_endpoint0;
    logic [15:0] alpha_endpoint1;
    logic [31:0] alpha_indices;
  } block_in_t;

  typedef struct packed {
    logic [1:0] pixel_row;
    logic [1:0] pixel_column;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pixel_out_t;

  typedef struct packed {
    logic [3:0][7:0] red;
    logic [3:0][7:0] green;
    logic [3:0][7:0] blue;
    logic [3:0][7:0] alpha;
    logic [31:0]     color_indices;
    logic [31:0]     alpha_indices;
  } palette_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // (a + 2b) / 3, truncated
  function automatic logic [7:0] third_mix(input logic [7:0] a, input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = {2'b00, a} + {1'b0, b, 1'b0};
    prod = {10'd0, sum} * 20'(Recip3);
    return prod[Recip3Shift +: 8];
  endfunction

endpackage

/* rtl/core/dxt1_block_with_alpha_decoder_unit.sv */
// path: the first pixel of a block passes the input, work and output registers in turn
// throughput: one pixel per cycle while pixel_ready is high and the next block is held
// a new block beat is taken while the previous block is still being emitted
// reset: synchronous, clears the input held flag, busy flag, pixel counter and output valid
module dxt1_block_with_alpha_decoder_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  block_valid,
  output logic                  block_ready,
  input  dxtba_pkg::block_in_t  block_data,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output dxtba_pkg::pixel_out_t pixel_data
);
  import dxtba_pkg::*;

  logic     src_valid;
  logic     src_take;
  palette_t src;

  dxtba_palette u_palette (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_data  (block_data),
    .src_valid   (src_valid),
    .src_take    (src_take),
    .src         (src)
  );

  dxtba_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_take    (src_take),
    .src         (src),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_data  (pixel_data)
  );

endmodule

/* rtl/core/dxtba_palette.sv */
// input register and four-entry colour and alpha palette build
module dxtba_palette (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 block_valid,
  output logic                 block_ready,
  input  dxtba_pkg::block_in_t block_data,
  output logic                 src_valid,
  input  logic                 src_take,
  output dxtba_pkg::palette_t  src
);
  import dxtba_pkg::*;

  logic      held;
  block_in_t blk;
  logic [7:0] r0, r1, g0, g1, b0, b1, a0, a1;

  assign block_ready = !held || src_take;
  assign src_valid   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (block_valid && block_ready) begin
      held <= 1'b1;
    end else if (src_take) begin
      held <= 1'b0;
    end
    if (block_valid && block_ready) begin
      blk <= block_data;
    end
  end

  always_comb begin
    r0 = expand5(blk.color_endpoint0[15:11]);
    g0 = expand6(blk.color_endpoint0[10:5]);
    b0 = expand5(blk.color_endpoint0[4:0]);
    r1 = expand5(blk.color_endpoint1[15:11]);
    g1 = expand6(blk.color_endpoint1[10:5]);
    b1 = expand5(blk.color_endpoint1[4:0]);
    a0 = expand6(blk.alpha_endpoint0[10:5]);
    a1 = expand6(blk.alpha_endpoint1[10:5]);

    src.red   = {third_mix(r0, r1), third_mix(r1, r0), r1, r0};
    src.green = {third_mix(g0, g1), third_mix(g1, g0), g1, g0};
    src.blue  = {third_mix(b0, b1), third_mix(b1, b0), b1, b0};
    src.alpha = {third_mix(a0, a1), third_mix(a1, a0), a1, a0};
    src.color_indices = blk.color_indices;
    src.alpha_indices = blk.alpha_indices;
  end

endmodule

/* rtl/core/dxtba_emitter.sv */
// walks the sixteen pixels of a block into the output register
module dxtba_emitter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_take,
  input  dxtba_pkg::palette_t   src,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output dxtba_pkg::pixel_out_t pixel_data
);
  import dxtba_pkg::*;

  logic                  busy;
  logic [CountWidth-1:0] cnt;
  palette_t              work;
  logic                  adv;
  logic                  at_last;
  logic [1:0]            ci;
  logic [1:0]            ai;

  assign at_last  = cnt == CountWidth'(PixelsPerBlock - 1);
  assign adv      = busy && (!pixel_valid || pixel_ready);
  assign src_take = src_valid && (!busy || (adv && at_last));
  assign ci       = work.color_indices[31:30];
  assign ai       = work.alpha_indices[31:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      pixel_valid <= 1'b0;
    end else begin
      if (adv) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
      if (src_take) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (adv) begin
        cnt <= cnt + 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end

    if (adv) begin
      pixel_data.pixel_row    <= cnt[3:2];
      pixel_data.pixel_column <= cnt[1:0];
      pixel_data.red          <= work.red[ci];
      pixel_data.green        <= work.green[ci];
      pixel_data.blue         <= work.blue[ci];
      pixel_data.alpha        <= work.alpha[ai];
      pixel_data.last_pixel   <= at_last;
    end

    // indices shift up so the current pixel always sits in the top two bits
    if (src_take) begin
      work <= src;
    end else if (adv) begin
      work.color_indices <= {work.color_indices[29:0], 2'b00};
      work.alpha_indices <= {work.alpha_indices[29:0], 2'b00};
    end
  end

endmodule

/* rtl/core/dxtba_checker.sv */
// port-level checks for the decoder and their bind to the top level
module dxtba_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  block_ready,
  input logic                  pixel_valid,
  input logic                  pixel_ready,
  input dxtba_pkg::pixel_out_t pixel_data
);
  import dxtba_pkg::*;

  // no pixel beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // a stalled pixel beat holds
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_data))
    else $error("stalled pixel beat changed");

  // last flag marks exactly the bottom-right pixel
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> pixel_data.last_pixel ==
      (pixel_data.pixel_row == 2'd3 && pixel_data.pixel_column == 2'd3))
    else $error("last pixel flag misplaced");

  // inside a block the next pixel follows at once in raster order
  a_raster: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready && !pixel_data.last_pixel |=>
      pixel_valid && {pixel_data.pixel_row, pixel_data.pixel_column} ==
        4'($past({pixel_data.pixel_row, pixel_data.pixel_column}) + 4'd1))
    else $error("pixel order broken");

  // the block input is ready right after reset, when nothing is pending in front of it
  a_first_block: assert property (@(posedge clk) rst |=> block_ready)
    else $error("block not ready after reset");

endmodule

bind dxt1_block_with_alpha_decoder_unit dxtba_checker u_dxtba_checker (
  .clk         (clk),
  .rst         (rst),
  .block_ready (block_ready),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .pixel_data  (pixel_data)
);

/* bench/dxt1_block_with_alpha_decoder_unit_tb.sv */
// self-checking testbench for the dxt1 block with alpha decoder unit
module dxt1_block_with_alpha_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dxtba_pkg::*;

  typedef struct packed {
    block_in_t   blk;
    logic        fixed;   // expected color typed in below, same for all 16 pixels
    logic [31:0] rgba;
  } block_case_t;

  localparam int NumDirected = 16;
  localparam int NumRandom = 260;

  logic       clk;
  logic       rst;
  logic       block_valid;
  logic       block_ready;
  block_in_t  block_data;
  logic       pixel_valid;
  logic       pixel_ready;
  pixel_out_t pixel_data;

  pixel_out_t pixels_due[$];
  int unsigned mismatches;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  block_case_t directed_blocks[NumDirected] = '{
    {16'h0000, 16'h0000, 32'h00000000, 16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000},
    {16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    {16'hFFFF, 16'h0000, 32'h00000000, 16'hFFFF, 16'h0000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
    {16'hFFFF, 16'h0000, 32'h55555555, 16'hFFFF, 16'h0000, 32'h55555555, 1'b1, 32'h00000000},
    {16'hFFFF, 16'h0000, 32'hAAAAAAAA, 16'hFFFF, 16'h0000, 32'hAAAAAAAA, 1'b1, 32'hAAAAAAAA},
    {16'hFFFF, 16'h0000, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 32'hFFFFFFFF, 1'b1, 32'h55555555},
    {16'h0000, 16'hFFFF, 32'hAAAAAAAA, 16'h0000, 16'hFFFF, 32'hAAAAAAAA, 1'b1, 32'h55555555},
    {16'h0000, 16'hFFFF, 32'hFFFFFFFF, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 32'hAAAAAAAA},
    // red and blue bits of the alpha words must be ignored
    {16'h0000, 16'h0000, 32'h00000000, 16'hF81F, 16'hF81F, 32'h00000000, 1'b1, 32'h00000000},
    {16'h0000, 16'h0000, 32'h00000000, 16'h07E0, 16'h0000, 32'h00000000, 1'b1, 32'h000000FF},
    {16'hFFFF, 16'hFFFF, 32'h00000000, 16'hF81F, 16'h07E0, 32'h55555555, 1'b1, 32'hFFFFFFFF},
    {16'hF800, 16'h001F, 32'h1B1B1B1B, 16'h07E0, 16'h0000, 32'hE4E4E4E4, 1'b0, 32'h00000000},
    {16'h07E0, 16'hF800, 32'hE4E4E4E4, 16'h0020, 16'h07C0, 32'h1B1B1B1B, 1'b0, 32'h00000000},
    {16'h1234, 16'hABCD, 32'h01234567, 16'h5A5A, 16'hA5A5, 32'h89ABCDEF, 1'b0, 32'h00000000},
    {16'h8410, 16'h7BEF, 32'hC6C6C6C6, 16'h8410, 16'h7BEF, 32'h39393939, 1'b0, 32'h00000000},
    {16'h0821, 16'hF7DE, 32'h93939393, 16'h0020, 16'h07C0, 32'h6C6C6C6C, 1'b0, 32'h00000000}
  };

  dxt1_block_with_alpha_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_data  (block_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_data  (pixel_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("** dxt1_block_with_alpha_decoder_unit: FAILED **");
    $finish;
  end

  // bit replication up to 8 bits
  function automatic int widen(input int v, input int bits);
    if (bits == 5) begin
      return ((v << 3) | (v >> 2)) & 255;
    end
    return ((v << 2) | (v >> 4)) & 255;
  endfunction

  function automatic int mix_third(input int a, input int b);
    return (a + 2 * b) / 3;
  endfunction

  // builds the palettes and queues the 16 pixels the block should emit
  function automatic void queue_pixels(input block_in_t b, input logic fixed,
                                       input logic [31:0] rgba);
    int red_pal[4];
    int grn_pal[4];
    int blu_pal[4];
    int alf_pal[4];
    int ci;
    int ai;
    pixel_out_t px;
    red_pal[0] = widen(int'(b.color_endpoint0[15:11]), 5);
    grn_pal[0] = widen(int'(b.color_endpoint0[10:5]), 6);
    blu_pal[0] = widen(int'(b.color_endpoint0[4:0]), 5);
    red_pal[1] = widen(int'(b.color_endpoint1[15:11]), 5);
    grn_pal[1] = widen(int'(b.color_endpoint1[10:5]), 6);
    blu_pal[1] = widen(int'(b.color_endpoint1[4:0]), 5);
    alf_pal[0] = widen(int'(b.alpha_endpoint0[10:5]), 6);
    alf_pal[1] = widen(int'(b.alpha_endpoint1[10:5]), 6);
    red_pal[2] = mix_third(red_pal[1], red_pal[0]);
    grn_pal[2] = mix_third(grn_pal[1], grn_pal[0]);
    blu_pal[2] = mix_third(blu_pal[1], blu_pal[0]);
    alf_pal[2] = mix_third(alf_pal[1], alf_pal[0]);
    red_pal[3] = mix_third(red_pal[0], red_pal[1]);
    grn_pal[3] = mix_third(grn_pal[0], grn_pal[1]);
    blu_pal[3] = mix_third(blu_pal[0], blu_pal[1]);
    alf_pal[3] = mix_third(alf_pal[0], alf_pal[1]);
    for (int i = 0; i < 16; i++) begin
      // pixel 0 takes the top two index bits
      ci = int'(b.color_indices[31 - 2 * i -: 2]);
      ai = int'(b.alpha_indices[31 - 2 * i -: 2]);
      px.pixel_row    = 2'(i >> 2);
      px.pixel_column = 2'(i & 3);
      px.red          = fixed ? rgba[31:24] : 8'(red_pal[ci]);
      px.green        = fixed ? rgba[23:16] : 8'(grn_pal[ci]);
      px.blue         = fixed ? rgba[15:8] : 8'(blu_pal[ci]);
      px.alpha        = fixed ? rgba[7:0] : 8'(alf_pal[ai]);
      px.last_pixel   = (i == 15);
      pixels_due.push_back(px);
    end
  endfunction

  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_indices();
    case ($urandom_range(0, 9))
      0: return 32'h00000000;
      1: return 32'h55555555;
      2: return 32'hAAAAAAAA;
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic block_in_t random_block();
    block_in_t b;
    b.color_endpoint0 = pick_endpoint();
    b.color_endpoint1 = pick_endpoint();
    b.color_indices   = pick_indices();
    b.alpha_endpoint0 = pick_endpoint();
    b.alpha_endpoint1 = pick_endpoint();
    b.alpha_indices   = pick_indices();
    return b;
  endfunction

  task automatic send_block(input block_in_t b, input logic fixed, input logic [31:0] rgba);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      block_valid <= 1'b0;
      @(posedge clk);
    end
    block_valid <= 1'b1;
    block_data  <= b;
    @(posedge clk);
    while (!block_ready) @(posedge clk);
    queue_pixels(b, fixed, rgba);
  endtask

  always @(posedge clk) begin
    pixel_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst && pixel_valid && pixel_ready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t: pixel beat with nothing expected: row %0d col %0d rgba %h %h %h %h last %b",
                 $time, pixel_data.pixel_row, pixel_data.pixel_column, pixel_data.red,
                 pixel_data.green, pixel_data.blue, pixel_data.alpha, pixel_data.last_pixel);
      end else begin
        want = pixels_due.pop_front();
        if (pixel_data.pixel_row !== want.pixel_row ||
            pixel_data.pixel_column !== want.pixel_column ||
            pixel_data.red !== want.red || pixel_data.green !== want.green ||
            pixel_data.blue !== want.blue || pixel_data.alpha !== want.alpha ||
            pixel_data.last_pixel !== want.last_pixel) begin
          mismatches++;
          $display("%0t: mismatch expected row %0d col %0d rgba %h %h %h %h last %b",
                   $time, want.pixel_row, want.pixel_column, want.red, want.green,
                   want.blue, want.alpha, want.last_pixel);
          $display("%0t:          actual   row %0d col %0d rgba %h %h %h %h last %b",
                   $time, pixel_data.pixel_row, pixel_data.pixel_column, pixel_data.red,
                   pixel_data.green, pixel_data.blue, pixel_data.alpha,
                   pixel_data.last_pixel);
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    rst           = 1'b1;
    block_valid   = 1'b0;
    block_data    = '0;
    mismatches    = 0;
    src_idle_pct  = 37;
    sink_idle_pct = 37;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_blocks[k]) begin
      send_block(directed_blocks[k].blk, directed_blocks[k].fixed, directed_blocks[k].rgba);
    end

    for (int n = 0; n < NumRandom; n++) begin
      // stretch with both sides running flat out
      if (n == 100) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (n == 160) begin
        src_idle_pct  = 37;
        sink_idle_pct = 37;
      end
      send_block(random_block(), 1'b0, 32'h0);
    end
    block_valid <= 1'b0;

    guard = 0;
    while (pixels_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pixels_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected pixels never arrived", $time, pixels_due.size());
    end

    if (mismatches == 0) begin
      $display("** dxt1_block_with_alpha_decoder_unit: PASSED **");
    end else begin
      $display("** dxt1_block_with_alpha_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
